// ===== sv/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and helpers for the PDF string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  // Emitted byte counter width; the limit is clipped to 2^LENGTH_BITS - 1
  localparam int LENGTH_BITS = 16;
  // Width used to compare the count against the limit
  localparam int CAP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  // Configuration register indexes
  localparam logic CFG_DECODE_MODE  = 1'b0;
  localparam logic CFG_OUTPUT_LIMIT = 1'b1;

  // Decode modes
  localparam logic MODE_LITERAL = 1'b0;
  localparam logic MODE_HEX     = 1'b1;

  // Escape phases
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESCAPE = 2'd1;
  localparam logic [1:0] PH_OCTAL  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

  // One result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_end;
    logic        truncated;
    logic [15:0] decoded_length;
  } res_t;

  // Results of one decoded item going into the result buffer
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_wr_t;

  // Octal digit test: '0' .. '7'
  function automatic logic is_octal(input logic [7:0] c);
    return (c[7:3] == 5'b00110);
  endfunction

  // Hex digit test and value: {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/psu_if.sv =====
// ----------------------------------------------------------------------------
// psu_if
// Valid/ready channels for raw string bytes and decoded result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface psu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        string_end;
  logic        truncated;
  logic [15:0] decoded_length;

  modport source (output valid, output out_byte, output byte_valid, output string_end,
                  output truncated, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                  input truncated, input decoded_length, output ready);
endinterface

`default_nettype wire

// ===== sv/psu_decode.sv =====
// ----------------------------------------------------------------------------
// psu_decode
// Escape and hex decoder: state registers plus single-pass decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_decode
  import psu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        decode_mode,
  input  wire logic [15:0] output_limit,
  input  wire logic        item_full,
  input  wire logic [7:0]  item_byte,
  input  wire logic        item_last,
  input  wire logic [1:0]  space,
  output logic             fire,
  output res_wr_t          wr
);

  logic [1:0]             escape_phase, escape_phase_next;
  logic [8:0]             octal_accum, octal_accum_next;
  logic [1:0]             octal_digits, octal_digits_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic                   nibble_pending, nibble_pending_next;
  logic [LENGTH_BITS-1:0] emitted_count, emitted_count_next;
  logic                   overflow_seen, overflow_seen_next;

  logic       c0v, c1v;
  logic [7:0] c0b, c1b;
  logic [4:0] hv;
  logic [8:0] acc_grow;
  logic [1:0] dig_grow;
  logic [CAP_W-1:0] lim_w, max_w, cap, cnt_w, cnt0_w, cnt1_w;
  logic       ok0, ok1, ovf0, ovf1;
  logic [1:0] nres;

  // Candidate bytes and next escape / nibble state
  always_comb begin
    c0v = 1'b0;
    c0b = 8'd0;
    c1v = 1'b0;
    c1b = 8'd0;
    escape_phase_next   = escape_phase;
    octal_accum_next    = octal_accum;
    octal_digits_next   = octal_digits;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    hv       = hex_value(item_byte);
    acc_grow = {octal_accum[5:0], item_byte[2:0]};
    dig_grow = octal_digits + 2'd1;
    if (decode_mode == MODE_HEX) begin
      if (hv[4]) begin
        if (!nibble_pending) begin
          high_nibble_next    = hv[3:0];
          nibble_pending_next = 1'b1;
          if (item_last) begin
            c0v = 1'b1;
            c0b = {hv[3:0], 4'd0};
            nibble_pending_next = 1'b0;
          end
        end else begin
          c0v = 1'b1;
          c0b = {high_nibble, hv[3:0]};
          nibble_pending_next = 1'b0;
        end
      end else if (item_last && nibble_pending) begin
        c0v = 1'b1;
        c0b = {high_nibble, 4'd0};
        nibble_pending_next = 1'b0;
      end
    end else begin
      case (escape_phase)
        PH_ESCAPE: begin
          escape_phase_next = PH_NORMAL;
          c0v = 1'b1;
          c0b = item_byte;
          if (item_byte == CH_N) begin
            c0b = CH_LF;
          end else if (item_byte == CH_R) begin
            c0b = CH_CR;
          end else if (item_byte == CH_T) begin
            c0b = CH_TAB;
          end else if (is_octal(item_byte)) begin
            octal_accum_next  = {6'd0, item_byte[2:0]};
            octal_digits_next = 2'd1;
            c0b = {5'd0, item_byte[2:0]};
            if (!item_last) begin
              c0v = 1'b0;
              escape_phase_next = PH_OCTAL;
            end
          end
        end
        PH_OCTAL: begin
          if (is_octal(item_byte) && octal_digits < 2'd3) begin
            octal_accum_next  = acc_grow;
            octal_digits_next = dig_grow;
            if (dig_grow == 2'd3 || item_last) begin
              c0v = 1'b1;
              c0b = acc_grow[7:0];
              escape_phase_next = PH_NORMAL;
            end
          end else begin
            // Cut escape: emit the value, then treat the byte as plain or as a new escape
            c0v = 1'b1;
            c0b = octal_accum[7:0];
            escape_phase_next = PH_NORMAL;
            if (item_byte == CH_BACKSLASH && !item_last) begin
              escape_phase_next = PH_ESCAPE;
            end else begin
              c1v = 1'b1;
              c1b = item_byte;
            end
          end
        end
        default: begin
          escape_phase_next = PH_NORMAL;
          if (item_byte == CH_BACKSLASH && !item_last) begin
            escape_phase_next = PH_ESCAPE;
          end else begin
            c0v = 1'b1;
            c0b = item_byte;
          end
        end
      endcase
    end
  end

  // Gate candidates against the output limit
  always_comb begin
    lim_w  = (output_limit == 16'd0) ? '0 : CAP_W'(output_limit - 16'd1);
    max_w  = CAP_W'((64'd1 << LENGTH_BITS) - 64'd1);
    cap    = (lim_w < max_w) ? lim_w : max_w;
    cnt_w  = CAP_W'(emitted_count);
    ok0    = c0v && (cnt_w < cap);
    ovf0   = overflow_seen | (c0v & ~ok0);
    cnt0_w = cnt_w + CAP_W'(ok0);
    ok1    = c1v && (cnt0_w < cap);
    ovf1   = ovf0 | (c1v & ~ok1);
    cnt1_w = cnt0_w + CAP_W'(ok1);
    emitted_count_next = LENGTH_BITS'(cnt1_w);
    overflow_seen_next = ovf1;
  end

  // Build result items
  always_comb begin
    wr.r0.out_byte       = c0b;
    wr.r0.byte_valid     = 1'b1;
    wr.r0.string_end     = 1'b0;
    wr.r0.truncated      = overflow_seen;
    wr.r0.decoded_length = cnt0_w[15:0];
    wr.r1.out_byte       = c1b;
    wr.r1.byte_valid     = 1'b1;
    wr.r1.string_end     = 1'b0;
    wr.r1.truncated      = ovf0;
    wr.r1.decoded_length = cnt1_w[15:0];
    nres = {1'b0, ok0} + {1'b0, ok1};
    if (item_last) begin
      if (!ok0) begin
        wr.r0.out_byte       = 8'd0;
        wr.r0.byte_valid     = 1'b0;
        wr.r0.string_end     = 1'b1;
        wr.r0.truncated      = ovf1;
        wr.r0.decoded_length = cnt_w[15:0];
        nres = 2'd1;
      end else if (!ok1) begin
        wr.r0.string_end = 1'b1;
        wr.r0.truncated  = ovf1;
      end else begin
        wr.r1.string_end = 1'b1;
        wr.r1.truncated  = ovf1;
      end
    end
    fire = item_full && (nres <= space);
    wr.n = fire ? nres : 2'd0;
  end

  // Advance decoder state when an item is decoded; clear at string end
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase   <= PH_NORMAL;
      octal_accum    <= '0;
      octal_digits   <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      emitted_count  <= '0;
      overflow_seen  <= 1'b0;
    end else if (fire) begin
      if (item_last) begin
        escape_phase   <= PH_NORMAL;
        octal_accum    <= '0;
        octal_digits   <= '0;
        high_nibble    <= '0;
        nibble_pending <= 1'b0;
        emitted_count  <= '0;
        overflow_seen  <= 1'b0;
      end else begin
        escape_phase   <= escape_phase_next;
        octal_accum    <= octal_accum_next;
        octal_digits   <= octal_digits_next;
        high_nibble    <= high_nibble_next;
        nibble_pending <= nibble_pending_next;
        emitted_count  <= emitted_count_next;
        overflow_seen  <= overflow_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/psu_res_buf.sv =====
// ----------------------------------------------------------------------------
// psu_res_buf
// Two-entry result buffer: takes up to two items a cycle as space allows, hands out one while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_res_buf
  import psu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire res_wr_t wr,
  output logic [1:0]   space,
  psu_out_if.source    res_out
);

  res_t       head, tail;
  logic [1:0] count, count_next;
  logic       pop;
  logic [1:0] rem_cnt;
  res_t       rem0, head_next, tail_next;

  // Compact what remains after a pop, then append new items
  always_comb begin
    pop     = res_out.valid && res_out.ready;
    rem_cnt = count - {1'b0, pop};
    rem0    = pop ? tail : head;
    space   = 2'd2 - rem_cnt;
    head_next = (rem_cnt == 2'd0) ? wr.r0 : rem0;
    case (rem_cnt)
      2'd0:    tail_next = wr.r1;
      2'd1:    tail_next = wr.r0;
      default: tail_next = tail;
    endcase
    count_next = rem_cnt + wr.n;
  end

  // Hold count; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

  assign res_out.valid          = (count != 2'd0);
  assign res_out.out_byte       = head.out_byte;
  assign res_out.byte_valid     = head.byte_valid;
  assign res_out.string_end     = head.string_end;
  assign res_out.truncated      = head.truncated;
  assign res_out.decoded_length = head.decoded_length;

endmodule

`default_nettype wire

// ===== sv/pdf_string_unescape.sv =====
// ----------------------------------------------------------------------------
// pdf_string_unescape
// PDF string body decoder: literal escapes or hex pairs, with output limit.
// ----------------------------------------------------------------------------
//  channel    dir  carries
//  byte_in    in   in_byte, last_byte (one raw body byte per item)
//  byte_out   out  out_byte, byte_valid, string_end, truncated, decoded_length
//  cfg_*      in   write-only registers: 0 decode_mode, 1 output_limit
//
//  One item per cycle while results drain: an input register feeds a single-pass
//  decoder that writes zero, one or two results into a two-entry result buffer.
//  An item waits in the input register until the buffer has free entries for
//  all its results, so input holds while it waits. Items pass through the
//  input register and the result buffer registers. Synchronous reset clears
//  the decoder state, the buffer and restores decode_mode 0, limit 256.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_string_unescape
  import psu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  psu_in_if.sink           byte_in,
  psu_out_if.source        byte_out
);

  logic        decode_mode;
  logic [15:0] output_limit;
  logic        item_full;
  logic [7:0]  item_byte;
  logic        item_last;
  logic        fire;
  logic [1:0]  space;
  res_wr_t     wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= MODE_LITERAL;
      output_limit <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DECODE_MODE:  decode_mode  <= cfg_data[0];
        CFG_OUTPUT_LIMIT: output_limit <= cfg_data;
        default:          decode_mode  <= decode_mode;
      endcase
    end
  end

  // Input register: load on accept, drop once decoded
  assign byte_in.ready = !item_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      item_full <= 1'b1;
    end else if (fire) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      item_byte <= byte_in.in_byte;
      item_last <= byte_in.last_byte;
    end
  end

  psu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .decode_mode  (decode_mode),
    .output_limit (output_limit),
    .item_full    (item_full),
    .item_byte    (item_byte),
    .item_last    (item_last),
    .space        (space),
    .fire         (fire),
    .wr           (wr)
  );

  psu_res_buf u_res_buf (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .space   (space),
    .res_out (byte_out)
  );

endmodule

`default_nettype wire
